// ===== rtl/ird_pkg.sv =====
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types and constants for the integer to radix digit converter.
// ----------------------------------------------------------------------------
package ird_pkg;

    localparam int MAX_DIGITS_DEF = 32;
    localparam int VALUE_BITS_DEF = 31;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_LD,
        ST_OUT
    } ird_state_t;

endpackage

// ===== rtl/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a non-negative integer into its digits in a configurable radix,
// most significant digit first, one output item per digit.
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake          payload
//  ----------   ---  ---------          -------
//  s_*          in   s_valid/s_ready    s_value
//  m_*          out  m_valid/m_ready    m_digit, m_digit_char, m_last_digit
//  cfg_*        in   cfg_wr_en          cfg_wr_data (radix, clamped to 2..36)
//
//  One restoring divider (one quotient bit per cycle) is reused for every
//  digit. Each digit is then read back from the digit memory in states RD
//  and LD and held in OUT until the output takes it. s_ready is high only
//  in idle. Reset (aresetn, synchronous) sets the radix to 10 and returns
//  to idle; the digit memory is not cleared.
//
module integer_to_radix_digits #(
    parameter int MAX_DIGITS = ird_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = ird_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [ird_pkg::RADIX_W-1:0]   cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [VALUE_BITS-1:0]         s_value,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ird_pkg::DIGIT_W-1:0]   m_digit,
    output logic [ird_pkg::CHAR_W-1:0]    m_digit_char,
    output logic                          m_last_digit
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int DW    = ird_pkg::DIGIT_W;
    localparam int RW    = ird_pkg::RADIX_W;

    // control
    ird_pkg::ird_state_t    state_reg, state_next;
    logic [RW-1:0]          radix_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic                   m_valid_reg, m_valid_next;

    // datapath
    logic [VALUE_BITS-1:0]  quo_reg, quo_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [DW-1:0]          dig_reg, dig_next;
    logic                   last_reg, last_next;

    // digit memory
    logic [DW-1:0]          mem [MAX_DIGITS];
    logic                   mem_we;
    logic [DW-1:0]          rd_data_reg;

    logic [RW-1:0]          radix_eff;
    logic [DW:0]            trial;
    logic                   trial_ge;
    logic [VALUE_BITS-1:0]  quo_shift;
    logic [DW-1:0]          rem_step;

    always_comb begin
        if (radix_reg < ird_pkg::RADIX_MIN) begin
            radix_eff = ird_pkg::RADIX_MIN;
        end else if (radix_reg > ird_pkg::RADIX_MAX) begin
            radix_eff = ird_pkg::RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    // shared divider step: bring down the next dividend bit, shift in a quotient bit
    assign trial     = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign trial_ge  = (trial >= {1'b0, radix_eff});
    assign quo_shift = {quo_reg[VALUE_BITS-2:0], trial_ge};
    assign rem_step  = trial_ge ? DW'(trial - {1'b0, radix_eff}) : trial[DW-1:0];

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rd_idx_next  = rd_idx_reg;
        bit_next     = bit_reg;
        m_valid_next = m_valid_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dig_next     = dig_reg;
        last_next    = last_reg;
        mem_we       = 1'b0;

        case (state_reg)
            ird_pkg::ST_IDLE: begin
                if (s_valid) begin
                    quo_next   = s_value;
                    rem_next   = '0;
                    bit_next   = '0;
                    cnt_next   = '0;
                    state_next = ird_pkg::ST_DIV;
                end
            end
            ird_pkg::ST_DIV: begin
                quo_next = quo_shift;
                rem_next = rem_step;
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(VALUE_BITS - 1)) begin
                    // digit done: store remainder, decide whether to go on
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    rem_next = '0;
                    bit_next = '0;
                    if (quo_shift == '0 ||
                        (cnt_reg + CNT_W'(1)) >= CNT_W'(MAX_DIGITS)) begin
                        rd_idx_next = cnt_reg;
                        state_next  = ird_pkg::ST_RD;
                    end
                end
            end
            ird_pkg::ST_RD: begin
                state_next = ird_pkg::ST_LD;
            end
            ird_pkg::ST_LD: begin
                dig_next     = rd_data_reg;
                last_next    = (rd_idx_reg == '0);
                m_valid_next = 1'b1;
                state_next   = ird_pkg::ST_OUT;
            end
            ird_pkg::ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (last_reg) begin
                        state_next = ird_pkg::ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg - CNT_W'(1);
                        state_next  = ird_pkg::ST_RD;
                    end
                end
            end
            default: begin
                state_next   = ird_pkg::ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ird_pkg::ST_IDLE;
            radix_reg   <= ird_pkg::RADIX_RESET;
            cnt_reg     <= '0;
            rd_idx_reg  <= '0;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_idx_reg  <= rd_idx_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                radix_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dig_reg  <= dig_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cnt_reg[IDX_W-1:0]] <= rem_step;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    assign s_ready      = (state_reg == ird_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_digit      = dig_reg;
    assign m_digit_char = ird_pkg::CHAR_ZERO + {1'b0, dig_reg};
    assign m_last_digit = last_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid_reg)
        else $error("input ready while an output item is pending");

    a_digit_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (dig_reg < radix_eff))
        else $error("digit not below radix");

    a_rd_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (rd_idx_reg < cnt_reg))
        else $error("read index beyond digit count");

    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ird_pkg::ST_DIV && cnt_reg == '0))
        else $error("accepted item did not start division");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count above limit");

endmodule
